// ===== sv/per_user_window_rate_limiter_assert.svh =====
// ----------------------------------------------------------------------------
// Rate limiter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef PER_USER_WINDOW_RATE_LIMITER_ASSERT_SVH
`define PER_USER_WINDOW_RATE_LIMITER_ASSERT_SVH

// same-cycle implication
`define PWRL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PWRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pwrl_pkg.sv =====
// ----------------------------------------------------------------------------
// pwrl_pkg
// Types, constants and helpers shared by the rate limiter modules.
// ----------------------------------------------------------------------------
package pwrl_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [31:0] MINUTE_LEN = 32'd60;
  localparam logic [31:0] HOUR_LEN   = 32'd3600;
  localparam logic [31:0] DAY_LEN    = 32'd86400;

  localparam logic [15:0] MINUTE_LIMIT_RST = 16'd10;
  localparam logic [15:0] HOUR_LIMIT_RST   = 16'd100;
  localparam logic [31:0] DAY_LIMIT_RST    = 32'd1000;

  typedef enum logic [1:0] {
    FUNC_CHECK = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_ALLOWED    = 3'd0,
    ST_DAY_CAP    = 3'd1,
    ST_MINUTE_CAP = 3'd2,
    ST_HOUR_CAP   = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_MINUTE_LIMIT = 2'd0,
    REG_HOUR_LIMIT   = 2'd1,
    REG_DAY_LIMIT    = 2'd2
  } reg_index_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic day_step;
    logic scan_step;
    logic misc;
    logic read;
    logic roll;
    logic decide;
    logic publish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t in_func;
    func_t func;
    logic  day_capped;
    logic  match;
    logic  free_avail;
    logic  scan_last;
    logic  out_busy;
  } stat_t;

  // per-entry window record
  typedef struct packed {
    logic [31:0] m_start;
    logic [15:0] m_count;
    logic [31:0] h_start;
    logic [15:0] h_count;
  } win_t;

  function automatic logic window_over(input logic [31:0] now,
                                       input logic [31:0] start,
                                       input logic [31:0] len);
    logic [31:0] diff;
    diff = now - start;
    return (now < start) || (diff >= len);
  endfunction

endpackage

// ===== sv/pwrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwrl_ctrl
// Sequencer: day check, entry walk, window roll, decision, result hand-off.
// ----------------------------------------------------------------------------
`include "per_user_window_rate_limiter_assert.svh"

module pwrl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pwrl_pkg::stat_t st,
  output pwrl_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DAY    = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_MISC   = 8'b0000_1000,
    S_READ   = 8'b0001_0000,
    S_ROLL   = 8'b0010_0000,
    S_DECIDE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (st.in_func)
            pwrl_pkg::FUNC_CHECK: state_next = S_DAY;
            pwrl_pkg::FUNC_QUERY: state_next = S_SCAN;
            default:              state_next = S_MISC;
          endcase
        end
      end
      S_DAY: begin
        cmd.day_step = 1'b1;
        state_next   = st.day_capped ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.match) begin
          state_next = S_READ;
        end else if (st.scan_last) begin
          // no hit: query or full table finish here, otherwise allocate
          if ((st.func == pwrl_pkg::FUNC_QUERY) || !st.free_avail) begin
            state_next = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_MISC: begin
        cmd.misc   = 1'b1;
        state_next = S_DONE;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_ROLL;
      end
      S_ROLL: begin
        cmd.roll   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `PWRL_ASSERT_NEXT(a_match_reads_entry, (state == S_SCAN) && st.match, state == S_READ, "hit did not lead to entry read")
  `PWRL_ASSERT_NEXT(a_day_cap_ends, (state == S_DAY) && st.day_capped, state == S_DONE, "day cap did not end transaction")

endmodule

// ===== sv/pwrl_dp.sv =====
// ----------------------------------------------------------------------------
// pwrl_dp
// Datapath: limit registers, day window, entry table, window memory, result.
// ----------------------------------------------------------------------------
`include "per_user_window_rate_limiter_assert.svh"

module pwrl_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic [1:0]      func,
  input  logic [15:0]     user_id,
  input  logic [31:0]     now_seconds,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      status,
  output logic [15:0]     minute_budget,
  output logic [15:0]     hour_budget,
  input  pwrl_pkg::cmd_t  cmd,
  output pwrl_pkg::stat_t st
);

  localparam int N = pwrl_pkg::MAX_ENTRIES;
  localparam int W = pwrl_pkg::IDX_W;

  // limit registers
  logic [15:0] minute_limit;
  logic [15:0] hour_limit;
  logic [31:0] day_limit;
  logic [15:0] cap_m;
  logic [15:0] cap_h;
  logic [31:0] cap_d;

  // captured transaction
  pwrl_pkg::func_t func_q;
  logic [15:0]     uid;
  logic [31:0]     now;

  // day window
  logic [31:0] day_start;
  logic [31:0] day_count;
  logic [31:0] day_inc;
  logic        day_over;
  logic        day_capped;

  // entry table
  logic [N-1:0] entry_used;
  logic [15:0]  entry_user [N];
  logic [W-1:0] scan_idx;
  logic [W-1:0] free_idx;
  logic [W-1:0] sel_idx;
  logic [W-1:0] alloc_idx;
  logic         free_found;
  logic         alloc_new;
  logic         cur_match;
  logic         cur_free;
  logic         scan_last;
  logic         free_avail;
  logic         scan_miss;
  logic         do_alloc;
  logic         do_full;
  logic         do_empty_query;

  // window memory and working copies
  pwrl_pkg::win_t win_mem [N];
  pwrl_pkg::win_t rd;
  pwrl_pkg::win_t base;
  pwrl_pkg::win_t w;
  pwrl_pkg::win_t wr;
  logic           m_over;
  logic           h_over;
  logic           charge_ok;

  // staged result
  pwrl_pkg::status_t res_status;
  pwrl_pkg::status_t decide_status;
  logic [15:0]       res_mrem;
  logic [15:0]       res_hrem;

  assign cfg_ready = 1'b1;
  assign cap_m     = (minute_limit == 16'd0) ? pwrl_pkg::MINUTE_LIMIT_RST : minute_limit;
  assign cap_h     = (hour_limit == 16'd0) ? pwrl_pkg::HOUR_LIMIT_RST : hour_limit;
  assign cap_d     = (day_limit == 32'd0) ? pwrl_pkg::DAY_LIMIT_RST : day_limit;

  assign day_over   = pwrl_pkg::window_over(now, day_start, pwrl_pkg::DAY_LEN);
  // a rolled day window is empty and every cap is at least one
  assign day_capped = !day_over && (day_count >= cap_d);
  assign day_inc    = (day_count == 32'hFFFF_FFFF) ? day_count : day_count + 32'd1;

  assign cur_match  = entry_used[scan_idx] && (entry_user[scan_idx] == uid);
  assign cur_free   = !entry_used[scan_idx];
  assign scan_last  = (scan_idx == W'(N - 1));
  assign free_avail = free_found || cur_free;
  assign alloc_idx  = free_found ? free_idx : scan_idx;

  assign scan_miss      = cmd.scan_step && !cur_match && scan_last;
  assign do_empty_query = scan_miss && (func_q == pwrl_pkg::FUNC_QUERY);
  assign do_alloc       = scan_miss && (func_q != pwrl_pkg::FUNC_QUERY) && free_avail;
  assign do_full        = scan_miss && (func_q != pwrl_pkg::FUNC_QUERY) && !free_avail;

  // fresh entries start from an all-zero record
  assign base   = alloc_new ? '0 : rd;
  assign m_over = pwrl_pkg::window_over(now, base.m_start, pwrl_pkg::MINUTE_LEN);
  assign h_over = pwrl_pkg::window_over(now, base.h_start, pwrl_pkg::HOUR_LEN);

  always_comb begin
    wr            = w;
    charge_ok     = 1'b0;
    decide_status = pwrl_pkg::ST_ALLOWED;
    if (w.m_count >= cap_m) begin
      decide_status = pwrl_pkg::ST_MINUTE_CAP;
    end else if (w.h_count >= cap_h) begin
      decide_status = pwrl_pkg::ST_HOUR_CAP;
    end else begin
      charge_ok  = 1'b1;
      wr.m_count = w.m_count + 16'd1;
      wr.h_count = w.h_count + 16'd1;
    end
    if (func_q != pwrl_pkg::FUNC_CHECK) begin
      wr        = w;
      charge_ok = 1'b0;
    end
  end

  assign st.in_func    = pwrl_pkg::func_t'(func);
  assign st.func       = func_q;
  assign st.day_capped = day_capped;
  assign st.match      = cur_match;
  assign st.free_avail = free_avail;
  assign st.scan_last  = scan_last;
  assign st.out_busy   = out_valid && !out_ready;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      minute_limit <= pwrl_pkg::MINUTE_LIMIT_RST;
      hour_limit   <= pwrl_pkg::HOUR_LIMIT_RST;
      day_limit    <= pwrl_pkg::DAY_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (pwrl_pkg::reg_index_t'(cfg_index))
        pwrl_pkg::REG_MINUTE_LIMIT: minute_limit <= cfg_data[15:0];
        pwrl_pkg::REG_HOUR_LIMIT:   hour_limit   <= cfg_data[15:0];
        pwrl_pkg::REG_DAY_LIMIT:    day_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // state that reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_used <= '0;
      day_start  <= '0;
      day_count  <= '0;
      free_found <= 1'b0;
      alloc_new  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        free_found <= 1'b0;
        alloc_new  <= 1'b0;
      end
      if (cmd.day_step && day_over) begin
        day_start <= now;
        day_count <= '0;
      end
      if (cmd.scan_step && cur_free && !free_found) begin
        free_found <= 1'b1;
      end
      if (do_alloc) begin
        entry_used[alloc_idx] <= 1'b1;
        alloc_new             <= 1'b1;
      end
      if (do_full || (cmd.decide && charge_ok)) begin
        day_count <= day_inc;
      end
      if (cmd.misc && (func_q == pwrl_pkg::FUNC_CLEAR)) begin
        entry_used <= '0;
        day_start  <= '0;
        day_count  <= '0;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q     <= pwrl_pkg::func_t'(func);
      uid        <= user_id;
      now        <= now_seconds;
      scan_idx   <= '0;
      res_status <= pwrl_pkg::ST_ALLOWED;
      res_mrem   <= '0;
      res_hrem   <= '0;
    end
    if (cmd.day_step && day_capped) begin
      res_status <= pwrl_pkg::ST_DAY_CAP;
    end
    if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (cur_free && !free_found) begin
        free_idx <= scan_idx;
      end
      if (cur_match) begin
        sel_idx <= scan_idx;
      end
    end
    if (do_empty_query) begin
      res_mrem <= cap_m;
      res_hrem <= cap_h;
    end
    if (do_alloc) begin
      sel_idx               <= alloc_idx;
      entry_user[alloc_idx] <= uid;
    end
    if (do_full) begin
      res_status <= pwrl_pkg::ST_TABLE_FULL;
    end
    if (cmd.roll) begin
      w.m_start <= m_over ? now : base.m_start;
      w.m_count <= m_over ? 16'd0 : base.m_count;
      w.h_start <= h_over ? now : base.h_start;
      w.h_count <= h_over ? 16'd0 : base.h_count;
    end
    if (cmd.decide) begin
      if (func_q == pwrl_pkg::FUNC_CHECK) begin
        res_status <= decide_status;
      end else begin
        res_mrem <= (w.m_count < cap_m) ? cap_m - w.m_count : 16'd0;
        res_hrem <= (w.h_count < cap_h) ? cap_h - w.h_count : 16'd0;
      end
    end
    if (cmd.publish) begin
      status        <= res_status;
      minute_budget <= res_mrem;
      hour_budget   <= res_hrem;
    end
  end

  // window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      win_mem[sel_idx] <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd <= win_mem[sel_idx];
    end
  end

  `PWRL_ASSERT_NEXT(a_charge_leaves_nonzero, cmd.decide && charge_ok, day_count != 32'd0, "charged day count is zero")
  `PWRL_ASSERT_NEXT(a_alloc_marks_entry, do_alloc, entry_used[sel_idx] && (entry_user[sel_idx] == uid), "allocated entry not marked for user")

endmodule

// ===== sv/per_user_window_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// per_user_window_rate_limiter
// Fixed-window call limiter: per-user minute and hour windows, global day cap.
// ----------------------------------------------------------------------------
// One transaction in, one result out, one transaction at a time. A check
// (func 0) runs the day check, which ends it when the day cap is hit, and
// otherwise the user search, the entry read, the window roll and the decision
// before the hand-off: the user search steps through the entry table one
// entry per cycle (up to MAX_ENTRIES = 16) and stops at the first hit; a miss
// walks the whole table to find the first free entry, and a miss on a full
// table ends right after the walk. A query (func 1) skips the day check and
// ends after the walk when the user has no entry; a clear or the unused code
// goes through a single misc step to the hand-off. The result sits in an
// output register, so the next transaction is taken while the previous
// result still waits for out_ready; a result that cannot be handed off holds
// the block in its final step. Limit registers (index 0 minute, 1 hour, 2 day)
// are written through the cfg channel, which is always ready; a limit of zero
// behaves as its reset value (10, 100, 1000). Write them only while the block
// is idle. Reset empties the table and the day window; no clearing pass runs.
// ----------------------------------------------------------------------------
module per_user_window_rate_limiter (
  input  logic        clk,
  input  logic        rst,
  // limit register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // request transaction
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [15:0] user_id,
  input  logic [31:0] now_seconds,
  // result transaction
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] minute_budget,
  output logic [15:0] hour_budget
);

  // sequencer commands and datapath status
  pwrl_pkg::cmd_t  cmd;
  pwrl_pkg::stat_t st;

  // controller: walks day check, entry search, roll, decide, hand-off
  pwrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: limits, day window, entry table, window memory, result regs
  pwrl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .func          (func),
    .user_id       (user_id),
    .now_seconds   (now_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .minute_budget (minute_budget),
    .hour_budget   (hour_budget),
    .cmd           (cmd),
    .st            (st)
  );

endmodule
